// ===== sv/ftc_pkg.sv =====
// ----------------------------------------------------------------------------
// ftc_pkg
// Shared types, codes and the payload condition function of the flow table
// classifier.
// ----------------------------------------------------------------------------
package ftc_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 16;

   localparam logic [7:0]  NO_MATCH_ACTION = 8'hFF;
   localparam logic [31:0] CNT_MAX         = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      CMD_CLASSIFY = 2'd0,
      CMD_WRITE    = 2'd1,
      CMD_READ     = 2'd2
   } cmd_type;

   localparam logic [3:0] OP_NONE  = 4'd0;
   localparam logic [3:0] OP_EQ    = 4'd1;
   localparam logic [3:0] OP_NE    = 4'd2;
   localparam logic [3:0] OP_GT    = 4'd3;
   localparam logic [3:0] OP_GE    = 4'd4;
   localparam logic [3:0] OP_LT    = 4'd5;
   localparam logic [3:0] OP_LE    = 4'd6;
   localparam logic [3:0] OP_GT_LT = 4'd7;
   localparam logic [3:0] OP_GE_LT = 4'd8;
   localparam logic [3:0] OP_GT_LE = 4'd9;
   localparam logic [3:0] OP_GE_LE = 4'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_ISSUE,
      ST_SCAN_CHECK,
      ST_READ_WAIT,
      ST_FINISH
   } ctl_state_type;

   typedef enum logic [1:0] {
      RD_REQ,
      RD_PTR,
      RD_NEXT
   } rd_sel_type;

   typedef struct packed {
      logic [7:0]  action;
      logic [31:0] source;
      logic [31:0] dest;
      logic [36:0] condition;
      logic [31:0] count;
   } row_type;

   typedef struct packed {
      logic       accept;
      logic       entry_write;
      logic       scan_start;
      logic       scan_next;
      logic       scan_hit;
      logic       read_load;
      logic       push;
      rd_sel_type rd_sel;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    idx_ok;
      logic    scan_last;
      logic    scan_hit;
      logic    out_free;
   } sts_type;

   function automatic logic cond_holds(input logic [36:0] cond, input logic [31:0] payload);
      logic [3:0]  op;
      logic [15:0] x1;
      logic [15:0] x2;
      logic [15:0] v1;
      logic [15:0] v2;
      logic        first;
      logic        result;
      op = cond[36:33];
      if (cond[32]) begin
         x1 = payload[15:0];
         x2 = payload[31:16];
         v1 = cond[15:0];
         v2 = cond[31:16];
      end else begin
         x1 = {8'd0, payload[7:0]};
         x2 = {8'd0, payload[15:8]};
         v1 = {8'd0, cond[7:0]};
         v2 = {8'd0, cond[23:16]};
      end
      case (op)
         OP_EQ:                      first = (x1 == v1);
         OP_NE:                      first = (x1 != v1);
         OP_GT, OP_GT_LT, OP_GT_LE:  first = (x1 > v1);
         OP_GE, OP_GE_LT, OP_GE_LE:  first = (x1 >= v1);
         OP_LT:                      first = (x1 < v1);
         OP_LE:                      first = (x1 <= v1);
         default:                    first = 1'b0;
      endcase
      case (op)
         OP_NONE:                                   result = 1'b1;
         OP_EQ, OP_NE, OP_GT, OP_GE, OP_LT, OP_LE:  result = first;
         OP_GT_LT, OP_GE_LT:                        result = first && (x2 < v2);
         OP_GT_LE, OP_GE_LE:                        result = first && (x2 <= v2);
         default:                                   result = 1'b0;
      endcase
      return result;
   endfunction

endpackage

// ===== sv/flow_table_packet_classifier.sv =====
// ----------------------------------------------------------------------------
// flow_table_packet_classifier
// First-match flow table with per-entry hit counters.
//
// Request channel (req_*, valid/stall) carries one command per item:
// classify a packet, write a table entry, or read an entry's hit counter.
// Response channel (rsp_*, valid/stall) returns exactly one item per request.
// Entries live in one RAM with a registered read port; the classify scan
// reads one entry per cycle from index 0 upward and stops at the first hit,
// writing the incremented counter back in the same cycle.
// From acceptance, a write or unknown command goes straight to ST_FINISH,
// a counter read with an in-range index passes ST_READ_WAIT, and a classify
// passes ST_SCAN_ISSUE and then ST_SCAN_CHECK for each entry it scans.
// One item is in flight at a time; the next is accepted the cycle after the
// result has moved to the output register.
// Reset clears all valid bits, counters read as zero and both channels idle.
// While rsp_stall holds, the response stays put; a finished result then
// waits and req_stall stays high.
// ----------------------------------------------------------------------------
module flow_table_packet_classifier #(
   parameter int TABLE_DEPTH = ftc_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [3:0]  req_entry_index,
   input  logic [15:0] req_pkt_source,
   input  logic [15:0] req_pkt_dest,
   input  logic [31:0] req_pkt_payload,
   input  logic        req_entry_enable,
   input  logic [7:0]  req_entry_action,
   input  logic [31:0] req_entry_source_match,
   input  logic [31:0] req_entry_dest_match,
   input  logic [36:0] req_entry_condition,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_matched,
   output logic [7:0]  rsp_action_code,
   output logic [3:0]  rsp_match_index,
   output logic [31:0] rsp_hit_count
);

   ftc_pkg::ctl_type       ctl;
   ftc_pkg::sts_type       sts;
   ftc_pkg::ctl_state_type state;

   ftc_ctrl u_ftc_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl),
      .state     (state)
   );

   ftc_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ftc_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .req_command            (req_command),
      .req_entry_index        (req_entry_index),
      .req_pkt_source         (req_pkt_source),
      .req_pkt_dest           (req_pkt_dest),
      .req_pkt_payload        (req_pkt_payload),
      .req_entry_enable       (req_entry_enable),
      .req_entry_action       (req_entry_action),
      .req_entry_source_match (req_entry_source_match),
      .req_entry_dest_match   (req_entry_dest_match),
      .req_entry_condition    (req_entry_condition),
      .ctl                    (ctl),
      .sts                    (sts),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_matched            (rsp_matched),
      .rsp_action_code        (rsp_action_code),
      .rsp_match_index        (rsp_match_index),
      .rsp_hit_count          (rsp_hit_count)
   );

   // busy in the cycle after taking an item
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted back to back");

   // a miss carries the no-match action and index zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_matched) |->
         (rsp_action_code == ftc_pkg::NO_MATCH_ACTION) && (rsp_match_index == 4'd0))
      else $error("miss with action or index set");

   // a hit never carries a counter value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_matched) |-> (rsp_hit_count == 32'd0))
      else $error("hit with counter value");

   // a scan hit only while the scan is checking an entry
   assert property (@(posedge clock) disable iff (reset)
      ctl.scan_hit |-> (state == ftc_pkg::ST_SCAN_CHECK))
      else $error("hit write-back outside scan");

endmodule

// ===== sv/ftc_ram.sv =====
// ----------------------------------------------------------------------------
// ftc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ftc_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [DATA_W-1:0]                     wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [DATA_W-1:0]                     rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/ftc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ftc_ctrl
// Command sequencer: accepts an item, steps the table scan or counter read
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module ftc_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ftc_pkg::sts_type sts,
   output ftc_pkg::ctl_type ctl,
   output ftc_pkg::ctl_state_type state
);

   ftc_pkg::ctl_state_type state_ff;
   ftc_pkg::ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ftc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ftc_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (sts.cmd)
                  ftc_pkg::CMD_CLASSIFY: state_in = ftc_pkg::ST_SCAN_ISSUE;
                  ftc_pkg::CMD_READ: begin
                     state_in = sts.idx_ok ? ftc_pkg::ST_READ_WAIT : ftc_pkg::ST_FINISH;
                  end
                  default: state_in = ftc_pkg::ST_FINISH;
               endcase
            end
         end
         ftc_pkg::ST_SCAN_ISSUE: state_in = ftc_pkg::ST_SCAN_CHECK;
         ftc_pkg::ST_SCAN_CHECK: begin
            if (sts.scan_hit || sts.scan_last) begin
               state_in = ftc_pkg::ST_FINISH;
            end
         end
         ftc_pkg::ST_READ_WAIT: state_in = ftc_pkg::ST_FINISH;
         ftc_pkg::ST_FINISH: begin
            if (sts.out_free) begin
               state_in = ftc_pkg::ST_IDLE;
            end
         end
         default: state_in = ftc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctl             = '0;
      ctl.rd_sel      = ftc_pkg::RD_PTR;
      req_stall       = 1'b1;
      case (state_ff)
         ftc_pkg::ST_IDLE: begin
            req_stall       = 1'b0;
            ctl.rd_sel      = ftc_pkg::RD_REQ;
            ctl.accept      = req_valid;
            ctl.scan_start  = req_valid;
            ctl.entry_write = req_valid && (sts.cmd == ftc_pkg::CMD_WRITE) && sts.idx_ok;
         end
         ftc_pkg::ST_SCAN_ISSUE: ctl.rd_sel = ftc_pkg::RD_PTR;
         ftc_pkg::ST_SCAN_CHECK: begin
            ctl.rd_sel    = ftc_pkg::RD_NEXT;
            ctl.scan_hit  = sts.scan_hit;
            ctl.scan_next = !sts.scan_hit && !sts.scan_last;
         end
         ftc_pkg::ST_READ_WAIT: ctl.read_load = 1'b1;
         ftc_pkg::ST_FINISH:    ctl.push = sts.out_free;
         default: ;
      endcase
   end

   assign state = state_ff;

endmodule

// ===== sv/ftc_datapath.sv =====
// ----------------------------------------------------------------------------
// ftc_datapath
// Entry store, valid bits, scan pointer, match logic, hit counter update and
// the result and output registers.
// ----------------------------------------------------------------------------
module ftc_datapath #(
   parameter int TABLE_DEPTH = ftc_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       req_command,
   input  logic [3:0]       req_entry_index,
   input  logic [15:0]      req_pkt_source,
   input  logic [15:0]      req_pkt_dest,
   input  logic [31:0]      req_pkt_payload,
   input  logic             req_entry_enable,
   input  logic [7:0]       req_entry_action,
   input  logic [31:0]      req_entry_source_match,
   input  logic [31:0]      req_entry_dest_match,
   input  logic [36:0]      req_entry_condition,
   input  ftc_pkg::ctl_type ctl,
   output ftc_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_matched,
   output logic [7:0]       rsp_action_code,
   output logic [3:0]       rsp_match_index,
   output logic [31:0]      rsp_hit_count
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int ROW_W = $bits(ftc_pkg::row_type);

   logic [TABLE_DEPTH-1:0] entry_valid_ff;
   logic [TABLE_DEPTH-1:0] written_ff;
   logic [IDX_W-1:0]       ptr_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [15:0]            src_ff;
   logic [15:0]            dst_ff;
   logic [31:0]            payload_ff;
   logic                   res_matched_ff;
   logic [7:0]             res_action_ff;
   logic [3:0]             res_index_ff;
   logic [31:0]            res_count_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_matched_ff;
   logic [7:0]             rsp_action_ff;
   logic [3:0]             rsp_index_ff;
   logic [31:0]            rsp_count_ff;

   logic [IDX_W-1:0]       req_addr;
   logic [IDX_W-1:0]       ram_waddr;
   logic [IDX_W-1:0]       ram_raddr;
   logic                   ram_we;
   ftc_pkg::row_type       wr_row;
   ftc_pkg::row_type       rd_row;
   logic [ROW_W-1:0]       rd_bits;
   logic                   scan_last;
   logic                   hit;
   logic [31:0]            count_inc;

   assign req_addr  = IDX_W'(req_entry_index);
   assign scan_last = (ptr_ff == IDX_W'(TABLE_DEPTH - 1));
   assign rd_row    = ftc_pkg::row_type'(rd_bits);
   assign count_inc = (rd_row.count == ftc_pkg::CNT_MAX) ? rd_row.count : rd_row.count + 32'd1;

   assign hit = entry_valid_ff[ptr_ff]
      && ftc_pkg::cond_holds(rd_row.condition, payload_ff)
      && (rd_row.source[31:16] == (src_ff & rd_row.source[15:0]))
      && (rd_row.dest[31:16] == (dst_ff & rd_row.dest[15:0]));

   always_comb begin
      case (ctl.rd_sel)
         ftc_pkg::RD_REQ:  ram_raddr = req_addr;
         ftc_pkg::RD_NEXT: ram_raddr = scan_last ? ptr_ff : IDX_W'(ptr_ff + 1'b1);
         default:          ram_raddr = ptr_ff;
      endcase
   end

   always_comb begin
      ram_we = ctl.entry_write || ctl.scan_hit;
      if (ctl.scan_hit) begin
         ram_waddr = ptr_ff;
         wr_row    = rd_row;
         wr_row.count = count_inc;
      end else begin
         ram_waddr        = req_addr;
         wr_row.action    = req_entry_action;
         wr_row.source    = req_entry_source_match;
         wr_row.dest      = req_entry_dest_match;
         wr_row.condition = req_entry_condition;
         wr_row.count     = '0;
      end
   end

   ftc_ram #(
      .DATA_W (ROW_W),
      .DEPTH  (TABLE_DEPTH)
   ) u_ftc_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (wr_row),
      .raddr (ram_raddr),
      .rdata (rd_bits)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         written_ff     <= '0;
         ptr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (ctl.entry_write) begin
            entry_valid_ff[req_addr] <= req_entry_enable;
            written_ff[req_addr]     <= 1'b1;
         end
         if (ctl.scan_start) begin
            ptr_ff <= '0;
         end else if (ctl.scan_next) begin
            ptr_ff <= IDX_W'(ptr_ff + 1'b1);
         end
         if (ctl.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         idx_ff         <= req_addr;
         src_ff         <= req_pkt_source;
         dst_ff         <= req_pkt_dest;
         payload_ff     <= req_pkt_payload;
         res_matched_ff <= 1'b0;
         res_action_ff  <= ftc_pkg::NO_MATCH_ACTION;
         res_index_ff   <= '0;
         res_count_ff   <= '0;
      end
      if (ctl.scan_hit) begin
         res_matched_ff <= 1'b1;
         res_action_ff  <= rd_row.action;
         res_index_ff   <= 4'(ptr_ff);
      end
      if (ctl.read_load) begin
         res_count_ff <= written_ff[idx_ff] ? rd_row.count : '0;
      end
      if (ctl.push) begin
         rsp_matched_ff <= res_matched_ff;
         rsp_action_ff  <= res_action_ff;
         rsp_index_ff   <= res_index_ff;
         rsp_count_ff   <= res_count_ff;
      end
   end

   always_comb begin
      sts.cmd       = ftc_pkg::cmd_type'(req_command);
      sts.idx_ok    = ({5'd0, req_entry_index} < 9'(TABLE_DEPTH));
      sts.scan_last = scan_last;
      sts.scan_hit  = hit;
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_matched     = rsp_matched_ff;
   assign rsp_action_code = rsp_action_ff;
   assign rsp_match_index = rsp_index_ff;
   assign rsp_hit_count   = rsp_count_ff;

endmodule
